@@ rtl/mpe_midi_byte_parser_defines.svh @@
// assertion macros for the mpe byte parser checker
// no dependencies; included by files that hold concurrent assertions
`ifndef MPE_MIDI_BYTE_PARSER_DEFINES_SVH
`define MPE_MIDI_BYTE_PARSER_DEFINES_SVH

// property checked while reset is low
`define MPE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define MPE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mpe_pkg.sv @@
// types and constants shared by the mpe byte parser
// no dependencies
`timescale 1ns / 1ps
package mpe_pkg;

   // pending message types
   localparam logic [2:0] TYPE_NOTEON   = 3'd0;
   localparam logic [2:0] TYPE_NOTEOFF  = 3'd1;
   localparam logic [2:0] TYPE_PRESSURE = 3'd2;
   localparam logic [2:0] TYPE_BEND     = 3'd3;
   localparam logic [2:0] TYPE_SLIDE    = 3'd4;
   localparam logic [2:0] TYPE_NONE     = 3'd7;

   // result kinds
   localparam logic [2:0] KIND_LIST     = 3'd0;
   localparam logic [2:0] KIND_NOTEON   = 3'd1;
   localparam logic [2:0] KIND_NOTEOFF  = 3'd2;
   localparam logic [2:0] KIND_PRESSURE = 3'd3;
   localparam logic [2:0] KIND_SLIDE    = 3'd4;
   localparam logic [2:0] KIND_BEND     = 3'd5;

   // status nibbles
   localparam logic [3:0] STATUS_NOTEOFF  = 4'h8;
   localparam logic [3:0] STATUS_NOTEON   = 4'h9;
   localparam logic [3:0] STATUS_CC       = 4'hB;
   localparam logic [3:0] STATUS_PRESSURE = 4'hD;
   localparam logic [3:0] STATUS_BEND     = 4'hE;

   localparam logic [6:0] SLIDE_CC = 7'd74;

   // one completed message handed from front to back
   typedef struct packed {
      logic [2:0] msg_kind;
      logic [3:0] channel;
      logic [6:0] first_data;
      logic [6:0] second_data;
   } msg_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

endpackage

@@ rtl/mpe_ifs.sv @@
// request and response channel interfaces of the mpe byte parser
// no dependencies
`timescale 1ns / 1ps
interface mpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] midi_byte;

   modport source (output valid, output midi_byte, input ready);
   modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [3:0]  member_channel;
   logic [6:0]  key_number;
   logic [6:0]  press_velocity;
   logic [6:0]  release_velocity;
   logic [13:0] amount;
   logic        last_of_run;

   modport source (output valid, output event_kind, output member_channel,
                   output key_number, output press_velocity,
                   output release_velocity, output amount, output last_of_run,
                   input ready);
   modport sink   (input valid, input event_kind, input member_channel,
                   input key_number, input press_velocity,
                   input release_velocity, input amount, input last_of_run,
                   output ready);
endinterface

@@ rtl/mpe_front.sv @@
// front end: takes midi bytes, tracks the pending message, pushes finished ones
// depends on mpe_pkg
`timescale 1ns / 1ps
module mpe_front
   import mpe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_valid,
   input  logic [7:0]     midi_byte,
   output logic           byte_ready,
   input  queue_stat_type q_stat,
   output logic           push,
   output msg_type        push_msg
);

   logic       msg_ready_ff, msg_ready_in;
   logic [2:0] ptype_ff, ptype_in;
   logic [3:0] pchan_ff, pchan_in;
   logic [6:0] first_ff, first_in;
   logic       accept;
   logic [2:0] status_type;

   assign byte_ready = !q_stat.full;
   assign accept     = byte_valid && byte_ready;

   always_comb begin
      case (midi_byte[7:4])
         STATUS_NOTEOFF:  status_type = TYPE_NOTEOFF;
         STATUS_NOTEON:   status_type = TYPE_NOTEON;
         STATUS_CC:       status_type = TYPE_SLIDE;
         STATUS_PRESSURE: status_type = TYPE_PRESSURE;
         STATUS_BEND:     status_type = TYPE_BEND;
         default:         status_type = TYPE_NONE;
      endcase
   end

   always_comb begin
      msg_ready_in = msg_ready_ff;
      ptype_in     = ptype_ff;
      pchan_in     = pchan_ff;
      first_in     = first_ff;
      push         = 1'b0;
      if (accept) begin
         if (midi_byte[7]) begin
            msg_ready_in = 1'b0;
            ptype_in     = TYPE_NONE;
            if (midi_byte[3:0] != 4'd0 && status_type != TYPE_NONE) begin
               ptype_in     = status_type;
               pchan_in     = midi_byte[3:0] - 4'd1;
               msg_ready_in = (status_type == TYPE_PRESSURE);
            end
         end else if (!msg_ready_ff) begin
            if (ptype_ff == TYPE_SLIDE) begin
               if (midi_byte[6:0] == SLIDE_CC) begin
                  msg_ready_in = 1'b1;
               end
            end else if (ptype_ff != TYPE_NONE) begin
               first_in     = midi_byte[6:0];
               msg_ready_in = 1'b1;
            end
         end else begin
            // completing data byte, no running status afterwards
            push         = 1'b1;
            msg_ready_in = 1'b0;
            ptype_in     = TYPE_NONE;
         end
      end
   end

   assign push_msg = '{msg_kind: ptype_ff, channel: pchan_ff,
                       first_data: first_ff, second_data: midi_byte[6:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_ready_ff <= 1'b0;
         ptype_ff     <= TYPE_NONE;
         pchan_ff     <= 4'd0;
         first_ff     <= 7'd0;
      end else begin
         msg_ready_ff <= msg_ready_in;
         ptype_ff     <= ptype_in;
         pchan_ff     <= pchan_in;
         first_ff     <= first_in;
      end
   end

endmodule

@@ rtl/mpe_queue.sv @@
// short message queue between front and back end
// depends on mpe_pkg
`timescale 1ns / 1ps
module mpe_queue
   import mpe_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  msg_type        push_msg,
   input  logic           pop,
   output msg_type        head_msg,
   output queue_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   msg_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == FULL_CNT);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head_msg     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_msg;
      end
   end

endmodule

@@ rtl/mpe_back.sv @@
// back end: turns queued messages into result beats through an output register
// depends on mpe_pkg
`timescale 1ns / 1ps
module mpe_back
   import mpe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  msg_type        head_msg,
   input  queue_stat_type q_stat,
   output logic           pop,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [2:0]     event_kind,
   output logic [3:0]     member_channel,
   output logic [6:0]     key_number,
   output logic [6:0]     press_velocity,
   output logic [6:0]     release_velocity,
   output logic [13:0]    amount,
   output logic           last_of_run
);

   logic        valid_ff, valid_in;
   logic        phase_ff, phase_in;
   logic        load;
   logic        is_note;
   logic [2:0]  kind_ff, kind_in;
   logic [3:0]  chan_ff;
   logic [6:0]  key_ff, key_in;
   logic [6:0]  press_ff, press_in;
   logic [6:0]  rel_ff, rel_in;
   logic [13:0] amount_ff, amount_in;
   logic        last_ff, last_in;

   assign is_note = (head_msg.msg_kind == TYPE_NOTEON) ||
                    (head_msg.msg_kind == TYPE_NOTEOFF);
   // output slot frees when empty or its beat is taken this cycle
   assign load    = (!valid_ff || out_ready) && !q_stat.empty;

   always_comb begin
      valid_in  = valid_ff && !out_ready;
      phase_in  = phase_ff;
      pop       = 1'b0;
      kind_in   = KIND_LIST;
      key_in    = 7'd0;
      press_in  = 7'd0;
      rel_in    = 7'd0;
      amount_in = 14'd0;
      last_in   = 1'b1;
      case (head_msg.msg_kind)
         TYPE_NOTEON: begin
            kind_in  = phase_ff ? KIND_NOTEON : KIND_LIST;
            key_in   = head_msg.first_data;
            press_in = head_msg.second_data;
            last_in  = phase_ff;
         end
         TYPE_NOTEOFF: begin
            kind_in = phase_ff ? KIND_NOTEOFF : KIND_LIST;
            key_in  = head_msg.first_data;
            rel_in  = head_msg.second_data;
            last_in = phase_ff;
         end
         TYPE_PRESSURE: begin
            kind_in   = KIND_PRESSURE;
            amount_in = {7'd0, head_msg.second_data};
         end
         TYPE_SLIDE: begin
            kind_in   = KIND_SLIDE;
            amount_in = {7'd0, head_msg.second_data};
         end
         TYPE_BEND: begin
            kind_in   = KIND_BEND;
            amount_in = {head_msg.second_data, head_msg.first_data};
         end
         default: begin
            kind_in = KIND_LIST;
         end
      endcase
      if (load) begin
         valid_in = 1'b1;
         // note messages stay at the head until their second beat is loaded
         if (is_note && !phase_ff) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            pop      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         chan_ff   <= head_msg.channel;
         key_ff    <= key_in;
         press_ff  <= press_in;
         rel_ff    <= rel_in;
         amount_ff <= amount_in;
         last_ff   <= last_in;
      end
   end

   assign out_valid        = valid_ff;
   assign event_kind       = kind_ff;
   assign member_channel   = chan_ff;
   assign key_number       = key_ff;
   assign press_velocity   = press_ff;
   assign release_velocity = rel_ff;
   assign amount           = amount_ff;
   assign last_of_run      = last_ff;

endmodule

@@ rtl/mpe_midi_byte_parser.sv @@
// a completing byte is written into the message queue, then loaded into the output register
// throughput: one byte per cycle while req ready is high; a note message gives two result beats
// the message queue between front and back absorbs the second beat of note events
// req ready drops only while the queue is full, which takes sustained rsp stalls
// synchronous active-high reset clears the pending message, queue and output valid
// no memory clearing pass: the block accepts bytes in the first cycle after reset
`timescale 1ns / 1ps
module mpe_midi_byte_parser
   import mpe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   mpe_req_if.sink   req_chan,
   mpe_rsp_if.source rsp_chan
);

   queue_stat_type q_stat;
   logic           push;
   logic           pop;
   msg_type        push_msg;
   msg_type        head_msg;

   mpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_chan.valid),
      .midi_byte  (req_chan.midi_byte),
      .byte_ready (req_chan.ready),
      .q_stat     (q_stat),
      .push       (push),
      .push_msg   (push_msg)
   );

   mpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_msg (push_msg),
      .pop      (pop),
      .head_msg (head_msg),
      .q_stat   (q_stat)
   );

   mpe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_msg         (head_msg),
      .q_stat           (q_stat),
      .pop              (pop),
      .out_valid        (rsp_chan.valid),
      .out_ready        (rsp_chan.ready),
      .event_kind       (rsp_chan.event_kind),
      .member_channel   (rsp_chan.member_channel),
      .key_number       (rsp_chan.key_number),
      .press_velocity   (rsp_chan.press_velocity),
      .release_velocity (rsp_chan.release_velocity),
      .amount           (rsp_chan.amount),
      .last_of_run      (rsp_chan.last_of_run)
   );

endmodule

@@ rtl/mpe_chk.sv @@
// port-level checker for the mpe byte parser, bound to the top level
// depends on mpe_pkg and mpe_midi_byte_parser_defines.svh
`timescale 1ns / 1ps
`include "mpe_midi_byte_parser_defines.svh"
module mpe_chk
   import mpe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_event_kind,
   input logic [3:0]  rsp_member_channel,
   input logic [13:0] rsp_amount,
   input logic        rsp_last_of_run
);

   // a waiting beat is not withdrawn
   `MPE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped")

   // only the note list beat of a note event is not the last of its run
   `MPE_ASSERT(a_first_is_list, clock, reset, rsp_valid && !rsp_last_of_run |-> rsp_event_kind == KIND_LIST && rsp_amount == 14'd0, "non-last beat is not a note list")

   // the named note beat follows its list beat at once, same channel
   `MPE_ASSERT(a_named_follows, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid && rsp_last_of_run && (rsp_event_kind == KIND_NOTEON || rsp_event_kind == KIND_NOTEOFF) && rsp_member_channel == $past(rsp_member_channel), "named note beat missing")

   // nothing offered right after reset
   `MPE_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "rsp valid after reset")

endmodule

bind mpe_midi_byte_parser mpe_chk u_mpe_chk (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_event_kind     (rsp_chan.event_kind),
   .rsp_member_channel (rsp_chan.member_channel),
   .rsp_amount         (rsp_chan.amount),
   .rsp_last_of_run    (rsp_chan.last_of_run)
);

@@ sim/tb_mpe_midi_byte_parser.sv @@
// self-checking testbench for the mpe midi byte parser
// depends on mpe_pkg, the req/rsp channel interfaces and mpe_midi_byte_parser
`timescale 1ns / 1ps
module tb_mpe_midi_byte_parser;
   import mpe_pkg::*;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  chan;
      logic [6:0]  key;
      logic [6:0]  press;
      logic [6:0]  rel;
      logic [13:0] amount;
      logic        last;
   } mpe_event_type;

   logic clock;
   logic reset;

   mpe_req_if req_if ();
   mpe_rsp_if rsp_if ();

   mpe_midi_byte_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // parser state as seen from the byte stream
   logic       msg_complete_next;
   logic [2:0] msg_ptype;
   logic [3:0] msg_chan;
   logic [6:0] msg_first;

   mpe_event_type expected_events[$];
   int            mismatch_count = 0;
   bit            no_idle = 0;

   localparam logic [3:0] STATUS_LIST[5] = '{STATUS_NOTEOFF, STATUS_NOTEON, STATUS_CC,
                                             STATUS_PRESSURE, STATUS_BEND};

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("** mpe_midi_byte_parser: FAILED **");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] rand_data();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'h7F;
      return 8'($urandom_range(0, 127));
   endfunction

   function automatic void queue_event(logic [2:0] kind, logic [6:0] key, logic [6:0] press,
                                       logic [6:0] rel, logic [13:0] amount, logic last);
      mpe_event_type ev;
      ev.kind   = kind;
      ev.chan   = msg_chan;
      ev.key    = key;
      ev.press  = press;
      ev.rel    = rel;
      ev.amount = amount;
      ev.last   = last;
      expected_events.push_back(ev);
   endfunction

   // advance the parser state by one accepted byte and queue the events it causes
   function automatic void parse_midi_byte(logic [7:0] b);
      if (b[7]) begin
         msg_complete_next = 1'b0;
         msg_ptype = TYPE_NONE;
         if (b[3:0] != 4'd0) begin
            case (b[7:4])
               STATUS_NOTEOFF:  msg_ptype = TYPE_NOTEOFF;
               STATUS_NOTEON:   msg_ptype = TYPE_NOTEON;
               STATUS_CC:       msg_ptype = TYPE_SLIDE;
               STATUS_PRESSURE: begin
                  msg_ptype = TYPE_PRESSURE;
                  msg_complete_next = 1'b1;
               end
               STATUS_BEND:     msg_ptype = TYPE_BEND;
               default:         msg_ptype = TYPE_NONE;
            endcase
            if (msg_ptype != TYPE_NONE) msg_chan = b[3:0] - 4'd1;
         end
      end else if (!msg_complete_next) begin
         if (msg_ptype == TYPE_SLIDE) begin
            if (b[6:0] == SLIDE_CC) msg_complete_next = 1'b1;
         end else if (msg_ptype != TYPE_NONE) begin
            msg_first = b[6:0];
            msg_complete_next = 1'b1;
         end
      end else begin
         case (msg_ptype)
            TYPE_NOTEON: begin
               queue_event(KIND_LIST, msg_first, b[6:0], 7'd0, 14'd0, 1'b0);
               queue_event(KIND_NOTEON, msg_first, b[6:0], 7'd0, 14'd0, 1'b1);
            end
            TYPE_NOTEOFF: begin
               queue_event(KIND_LIST, msg_first, 7'd0, b[6:0], 14'd0, 1'b0);
               queue_event(KIND_NOTEOFF, msg_first, 7'd0, b[6:0], 14'd0, 1'b1);
            end
            TYPE_PRESSURE: queue_event(KIND_PRESSURE, 7'd0, 7'd0, 7'd0, {7'd0, b[6:0]}, 1'b1);
            TYPE_SLIDE:    queue_event(KIND_SLIDE, 7'd0, 7'd0, 7'd0, {7'd0, b[6:0]}, 1'b1);
            TYPE_BEND:     queue_event(KIND_BEND, 7'd0, 7'd0, 7'd0, {b[6:0], msg_first}, 1'b1);
            default: ;
         endcase
         msg_complete_next = 1'b0;
         msg_ptype = TYPE_NONE;
      end
   endfunction

   // valid stays high on return so back-to-back beats need no extra step
   task automatic send_midi_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.midi_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      parse_midi_byte(b);
   endtask

   // response side back-pressure
   initial begin
      int gap;
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      mpe_event_type ev;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_events.size() == 0) begin
            $error("unexpected result beat: kind %0d channel %0d", rsp_if.event_kind,
                   rsp_if.member_channel);
            mismatch_count++;
         end else begin
            ev = expected_events.pop_front();
            check_field("event_kind", ev.kind, rsp_if.event_kind);
            check_field("member_channel", ev.chan, rsp_if.member_channel);
            check_field("key_number", ev.key, rsp_if.key_number);
            check_field("press_velocity", ev.press, rsp_if.press_velocity);
            check_field("release_velocity", ev.rel, rsp_if.release_velocity);
            check_field("amount", ev.amount, rsp_if.amount);
            check_field("last_of_run", ev.last, rsp_if.last_of_run);
         end
      end
   end

   task automatic test_note_messages();
      // note-on lowest key, full velocity; note-off top key on last member channel
      send_midi_byte({STATUS_NOTEON, 4'h1});
      send_midi_byte(8'h00);
      send_midi_byte(8'h7F);
      send_midi_byte({STATUS_NOTEOFF, 4'hF});
      send_midi_byte(8'h7F);
      send_midi_byte(8'h00);
   endtask

   task automatic test_control_messages();
      send_midi_byte({STATUS_PRESSURE, 4'h5});
      send_midi_byte(8'h7F);
      // cc waits for the slide controller number, other data ignored
      send_midi_byte({STATUS_CC, 4'h3});
      send_midi_byte(8'h10);
      send_midi_byte({1'b0, SLIDE_CC});
      send_midi_byte(8'h00);
      send_midi_byte({STATUS_BEND, 4'h1});
      send_midi_byte(8'h7F);
      send_midi_byte(8'h7F);
   endtask

   task automatic test_status_special_cases();
      // channel nibble zero opens nothing
      send_midi_byte({STATUS_NOTEON, 4'h0});
      send_midi_byte(8'h40);
      // system status opens nothing
      send_midi_byte(8'hF7);
      send_midi_byte(8'h05);
      // status mid-message drops it; data after completion is ignored
      send_midi_byte({STATUS_NOTEON, 4'h2});
      send_midi_byte(8'h40);
      send_midi_byte({STATUS_PRESSURE, 4'h3});
      send_midi_byte(8'h7F);
      send_midi_byte(8'h7F);
   endtask

   task automatic test_random_stream();
      int         sent;
      int         r;
      logic [3:0] st;
      logic [3:0] nib;
      sent = 0;
      while (sent < 500) begin
         if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
         r   = $urandom_range(0, 99);
         st  = STATUS_LIST[$urandom_range(0, 4)];
         nib = ($urandom_range(0, 15) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
         if (r < 85) begin
            send_midi_byte({st, nib});
            sent++;
            if (st == STATUS_CC) begin
               repeat ($urandom_range(0, 2)) begin
                  send_midi_byte(rand_data());
                  sent++;
               end
               if ($urandom_range(0, 7) != 0) begin
                  send_midi_byte({1'b0, SLIDE_CC});
                  sent++;
               end
            end
            send_midi_byte(rand_data());
            sent++;
            if (st == STATUS_NOTEON || st == STATUS_NOTEOFF || st == STATUS_BEND) begin
               send_midi_byte(rand_data());
               sent++;
            end
            // stray data byte after the message
            if ($urandom_range(0, 9) == 0) begin
               send_midi_byte(rand_data());
               sent++;
            end
         end else if (r < 93) begin
            // status with one data byte; a message that needs more is cut short by the next status
            send_midi_byte({st, nib});
            send_midi_byte(rand_data());
            sent += 2;
         end else begin
            send_midi_byte(8'($urandom_range(0, 255)));
            sent++;
         end
      end
      no_idle = 0;
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      <= 1'b0;
      req_if.midi_byte  <= 8'h00;
      msg_complete_next = 1'b0;
      msg_ptype         = TYPE_NONE;
      msg_chan          = 4'd0;
      msg_first         = 7'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_note_messages();
      test_control_messages();
      test_status_special_cases();
      test_random_stream();
      req_if.valid <= 1'b0;

      while (expected_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("** mpe_midi_byte_parser: PASSED **");
      else
         $display("** mpe_midi_byte_parser: FAILED **");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mpe_pkg.sv
rtl/mpe_ifs.sv
rtl/mpe_front.sv
rtl/mpe_queue.sv
rtl/mpe_back.sv
rtl/mpe_midi_byte_parser.sv
rtl/mpe_chk.sv
sim/tb_mpe_midi_byte_parser.sv
